[hw/rtl/mips_integer_subset_execute_top_macros.svh]
// Assertion macros for the execute block.
`ifndef MIPS_INTEGER_SUBSET_EXECUTE_TOP_MACROS_SVH
`define MIPS_INTEGER_SUBSET_EXECUTE_TOP_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define MIE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define MIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/mie_pkg.sv]
// Package with opcodes, constants and shared types of the execute block.
package mie_pkg;
  localparam int unsigned DataWordsDefault = 1024;
  localparam logic [31:0] StartPcReset  = 32'h0040_0000;
  localparam logic [31:0] DataBaseReset = 32'h1000_0000;

  localparam logic [0:0] CfgStartPc  = 1'b0;
  localparam logic [0:0] CfgDataBase = 1'b1;

  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpJ       = 6'h02;
  localparam logic [5:0] OpJal     = 6'h03;
  localparam logic [5:0] OpBeq     = 6'h04;
  localparam logic [5:0] OpBne     = 6'h05;
  localparam logic [5:0] OpAddiu   = 6'h09;
  localparam logic [5:0] OpSltiu   = 6'h0b;
  localparam logic [5:0] OpAndi    = 6'h0c;
  localparam logic [5:0] OpOri     = 6'h0d;
  localparam logic [5:0] OpLui     = 6'h0f;
  localparam logic [5:0] OpLb      = 6'h20;
  localparam logic [5:0] OpLw      = 6'h23;
  localparam logic [5:0] OpSb      = 6'h28;
  localparam logic [5:0] OpSw      = 6'h2b;

  localparam logic [5:0] FnSll  = 6'h00;
  localparam logic [5:0] FnSrl  = 6'h02;
  localparam logic [5:0] FnJr   = 6'h08;
  localparam logic [5:0] FnAddu = 6'h21;
  localparam logic [5:0] FnSubu = 6'h23;
  localparam logic [5:0] FnAnd  = 6'h24;
  localparam logic [5:0] FnOr   = 6'h25;
  localparam logic [5:0] FnNor  = 6'h27;
  localparam logic [5:0] FnSltu = 6'h2b;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_NOR, OP_SLTU, OP_SLL, OP_SRL,
    OP_LUI, OP_JR, OP_BEQ, OP_BNE, OP_J, OP_JAL, OP_ILLEGAL
  } op_t;

  // Back end sequencing: memory clear, execute, memory access.
  typedef enum logic [1:0] {S_CLEAR, S_EXEC, S_MEM} state_t;

  // Decoded instruction handed from the front to the back.
  typedef struct packed {
    op_t         op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  wdst;
    logic        wen;
    logic        use_imm;
    logic [31:0] imm;
    logic [4:0]  sh;
    logic [25:0] target;
    logic        load;
    logic        load_byte;
    logic        store;
    logic        store_byte;
  } dec_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write_enable;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        mem_write_enable;
    logic        mem_byte_write;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic        illegal_instruction;
  } res_t;
endpackage

[hw/rtl/mie_ram.sv]
// Generic RAM with one write port and one registered read port.
module mie_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/mie_front.sv]
// Front end: decode instructions into a two-entry queue.
module mie_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [31:0]    instruction,
  output logic           dq_valid,
  output mie_pkg::dec_t  dq_data,
  input  logic           dq_take
);
  import mie_pkg::*;

  dec_t d;
  dec_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic [5:0] opc, fn;
  logic [31:0] sx;

  assign opc = instruction[31:26];
  assign fn  = instruction[5:0];
  assign sx  = {{16{instruction[15]}}, instruction[15:0]};

  always_comb begin
    d = '0;
    d.rs = instruction[25:21];
    d.rt = instruction[20:16];
    d.sh = instruction[10:6];
    d.target = instruction[25:0];
    d.imm = sx;
    d.wdst = instruction[20:16];
    d.op = OP_ILLEGAL;
    case (opc)
      OpSpecial: begin
        d.wdst = instruction[15:11];
        d.wen = 1'b1;
        case (fn)
          FnAddu: d.op = OP_ADD;
          FnSubu: d.op = OP_SUB;
          FnAnd:  d.op = OP_AND;
          FnOr:   d.op = OP_OR;
          FnNor:  d.op = OP_NOR;
          FnSltu: d.op = OP_SLTU;
          FnSll:  d.op = OP_SLL;
          FnSrl:  d.op = OP_SRL;
          FnJr: begin
            d.op = OP_JR;
            d.wen = 1'b0;
          end
          default: d.wen = 1'b0;
        endcase
      end
      OpAddiu: begin d.op = OP_ADD; d.wen = 1'b1; d.use_imm = 1'b1; end
      OpAndi: begin
        d.op = OP_AND; d.wen = 1'b1; d.use_imm = 1'b1;
        d.imm = {16'h0, instruction[15:0]};
      end
      OpOri: begin
        d.op = OP_OR; d.wen = 1'b1; d.use_imm = 1'b1;
        d.imm = {16'h0, instruction[15:0]};
      end
      OpSltiu: begin d.op = OP_SLTU; d.wen = 1'b1; d.use_imm = 1'b1; end
      OpLui: begin d.op = OP_LUI; d.wen = 1'b1; end
      OpBeq: d.op = OP_BEQ;
      OpBne: d.op = OP_BNE;
      OpJ:   d.op = OP_J;
      OpJal: begin d.op = OP_JAL; d.wen = 1'b1; d.wdst = 5'd31; end
      OpLw:  begin d.op = OP_ADD; d.load = 1'b1; d.wen = 1'b1; end
      OpLb:  begin d.op = OP_ADD; d.load = 1'b1; d.load_byte = 1'b1; d.wen = 1'b1; end
      OpSw:  begin d.op = OP_ADD; d.store = 1'b1; end
      OpSb:  begin d.op = OP_ADD; d.store = 1'b1; d.store_byte = 1'b1; end
      default: d.op = OP_ILLEGAL;
    endcase
    if (d.wdst == 5'd0) d.wen = 1'b0;
  end

  logic do_push;
  assign full = count[1];
  assign do_push = push && !full;
  assign dq_valid = count != 2'd0;
  assign dq_data = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= d;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (dq_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, dq_take};
    end
  end
endmodule

[hw/rtl/mie_back.sv]
// Back end: register file, data memory and result queue.
module mie_back #(
  parameter int unsigned DataWords = mie_pkg::DataWordsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          dq_valid,
  input  mie_pkg::dec_t dq_data,
  output logic          dq_take,
  input  logic [31:0]   start_pc,
  input  logic [31:0]   data_base,
  output logic          busy_clear,
  output logic          res_valid,
  output mie_pkg::res_t res_data,
  input  logic          res_take
);
  import mie_pkg::*;
  localparam int unsigned Aw = $clog2(DataWords);

  state_t state, state_next;

  logic [31:0] pc;
  logic [31:0] regs [32];
  logic [Aw-1:0] clr_idx;
  dec_t cur;
  logic [31:0] a, b, opb, alu, sum;
  res_t r;
  logic [31:0] off;
  logic [Aw-1:0] widx;
  logic [1:0] lane;
  logic [31:0] rdata;
  logic ram_we;
  logic [Aw-1:0] ram_waddr;
  logic [31:0] ram_wdata;
  res_t mres;
  res_t mload;
  logic [Aw-1:0] maddr_idx;
  logic [1:0] mlane;
  logic [7:0] lbyte;
  logic [31:0] sb_word;

  // Result skid queue of two entries.
  res_t rq [2];
  logic rq_rd, rq_wr;
  logic [1:0] rq_cnt;
  logic rq_push;
  res_t rq_in;

  assign busy_clear = state == S_CLEAR;
  assign cur = dq_data;
  assign a = (cur.rs == 5'd0) ? 32'h0 : regs[cur.rs];
  assign b = (cur.rt == 5'd0) ? 32'h0 : regs[cur.rt];
  assign opb = cur.use_imm ? cur.imm : b;
  assign sum = a + cur.imm;
  assign off = sum - data_base;
  assign widx = off[Aw+1:2];
  assign lane = off[1:0];

  always_comb begin
    alu = 32'h0;
    case (cur.op)
      OP_ADD:  alu = a + opb;
      OP_SUB:  alu = a - opb;
      OP_AND:  alu = a & opb;
      OP_OR:   alu = a | opb;
      OP_NOR:  alu = ~(a | opb);
      OP_SLTU: alu = {31'h0, a < opb};
      OP_SLL:  alu = b << cur.sh;
      OP_SRL:  alu = b >> cur.sh;
      OP_LUI:  alu = {cur.imm[15:0], 16'h0};
      OP_JAL:  alu = pc + 32'd4;
      default: alu = 32'h0;
    endcase
  end

  always_comb begin
    r = '0;
    r.next_pc = pc + 32'd4;
    case (cur.op)
      OP_JR:  r.next_pc = a;
      OP_BEQ: if (a == b) r.next_pc = pc + 32'd4 + {cur.imm[29:0], 2'b00};
      OP_BNE: if (a != b) r.next_pc = pc + 32'd4 + {cur.imm[29:0], 2'b00};
      OP_J, OP_JAL: r.next_pc = {r.next_pc[31:28], cur.target, 2'b00};
      OP_ILLEGAL: begin
        r.next_pc = pc;
        r.illegal_instruction = 1'b1;
      end
      default: ;
    endcase
    if (cur.wen && !cur.load) begin
      r.reg_write_enable = 1'b1;
      r.reg_write_index = cur.wdst;
      r.reg_write_value = alu;
    end
    if (cur.load || cur.store) r.mem_address = sum;
    if (cur.store) begin
      r.mem_write_enable = 1'b1;
      r.mem_byte_write = cur.store_byte;
      r.mem_write_data = cur.store_byte ? {24'h0, b[7:0]} : b;
    end
  end

  // Hold the load or byte store; mem_write_enable marks lb here.
  always_comb begin
    mload = r;
    mload.reg_write_index = cur.load ? (cur.wen ? cur.wdst : 5'd0) : 5'd0;
    mload.mem_write_enable = cur.load ? cur.load_byte : 1'b1;
  end

  // Loads and byte stores read memory and finish in the memory state.
  logic go, need_mem;
  assign need_mem = cur.load || (cur.store && cur.store_byte);
  assign go = state == S_EXEC && dq_valid && !rq_cnt[1];
  assign dq_take = go;

  assign lbyte = rdata[5'(5'd24 - {mlane, 3'b000}) +: 8];
  always_comb begin
    sb_word = rdata;
    sb_word[5'(5'd24 - {mlane, 3'b000}) +: 8] = mres.mem_write_data[7:0];
  end

  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = 32'h0;
    rq_push = 1'b0;
    rq_in = r;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_idx == Aw'(DataWords - 1)) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (go) begin
          if (need_mem) state_next = S_MEM;
          else begin
            rq_push = 1'b1;
            if (cur.store) begin
              ram_we = 1'b1;
              ram_waddr = widx;
              ram_wdata = b;
            end
          end
        end
      end
      S_MEM: begin
        rq_push = 1'b1;
        rq_in = mres;
        state_next = S_EXEC;
        if (mres.mem_byte_write) begin
          ram_we = 1'b1;
          ram_waddr = maddr_idx;
          ram_wdata = sb_word;
        end else if (mres.reg_write_index != 5'd0) begin
          rq_in.reg_write_enable = 1'b1;
          rq_in.reg_write_value = mres.mem_write_enable
            ? {{24{lbyte[7]}}, lbyte} : rdata;
          rq_in.mem_write_enable = 1'b0;
        end else begin
          rq_in.reg_write_index = 5'd0;
          rq_in.mem_write_enable = 1'b0;
        end
      end
      default: state_next = S_EXEC;
    endcase
  end

  mie_ram #(.Width(32), .Depth(DataWords)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(widx), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (go && need_mem) begin
      mres <= mload;
      maddr_idx <= widx;
      mlane <= lane;
    end
    if (rq_push) rq[rq_wr] <= rq_in;
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      pc <= start_pc;
      rq_rd <= 1'b0;
      rq_wr <= 1'b0;
      rq_cnt <= 2'd0;
      for (int i = 0; i < 32; i++) regs[i] <= 32'h0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (go) pc <= r.next_pc;
      if (go && !need_mem && r.reg_write_enable)
        regs[r.reg_write_index] <= r.reg_write_value;
      if (state == S_MEM && rq_in.reg_write_enable)
        regs[rq_in.reg_write_index] <= rq_in.reg_write_value;
      if (rq_push) rq_wr <= ~rq_wr;
      if (res_take) rq_rd <= ~rq_rd;
      rq_cnt <= rq_cnt + {1'b0, rq_push} - {1'b0, res_take};
    end
  end

  assign res_valid = rq_cnt != 2'd0;
  assign res_data = rq[rq_rd];
endmodule

[hw/rtl/mips_integer_subset_execute_top.sv]
// Throughput: one instruction per cycle for register and branch work while the
// result queue has room; loads and byte stores also pass through the memory state,
// where the back end takes no new instruction, for the data memory read port.
// Reset: rst clears registers and the PC loads start_pc, then a clearing pass
// writes zero to each of DATA_WORDS memory words, one per cycle, while full is high.
// Top level of the execute block.
module mips_integer_subset_execute_top #(
  parameter int unsigned DATA_WORDS = mie_pkg::DataWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] instruction,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] next_pc,
  output logic        reg_write_enable,
  output logic [4:0]  reg_write_index,
  output logic [31:0] reg_write_value,
  output logic        mem_write_enable,
  output logic        mem_byte_write,
  output logic [31:0] mem_address,
  output logic [31:0] mem_write_data,
  output logic        illegal_instruction,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mie_pkg::*;
  `include "mips_integer_subset_execute_top_macros.svh"

  logic [31:0] start_pc, data_base;
  logic dq_valid, dq_take, busy_clear, res_valid, res_take, fe_full;
  dec_t dq_data;
  res_t res_data;

  // Config registers; start_pc only takes effect at the next reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= StartPcReset;
      data_base <= DataBaseReset;
    end else if (cfg_we) begin
      if (cfg_index == CfgStartPc) start_pc <= cfg_data;
      if (cfg_index == CfgDataBase) data_base <= cfg_data;
    end
  end

  // Hold input off during the memory clearing pass.
  assign full = fe_full || busy_clear;

  mie_front u_front (
    .clk(clk), .rst(rst), .push(push && !busy_clear), .full(fe_full),
    .instruction(instruction), .dq_valid(dq_valid), .dq_data(dq_data),
    .dq_take(dq_take)
  );

  mie_back #(.DataWords(DATA_WORDS)) u_back (
    .clk(clk), .rst(rst), .dq_valid(dq_valid), .dq_data(dq_data),
    .dq_take(dq_take), .start_pc(start_pc), .data_base(data_base),
    .busy_clear(busy_clear), .res_valid(res_valid), .res_data(res_data),
    .res_take(res_take)
  );

  assign empty = !res_valid;
  assign res_take = pop && res_valid;
  assign next_pc = res_data.next_pc;
  assign reg_write_enable = res_data.reg_write_enable;
  assign reg_write_index = res_data.reg_write_index;
  assign reg_write_value = res_data.reg_write_value;
  assign mem_write_enable = res_data.mem_write_enable;
  assign mem_byte_write = res_data.mem_byte_write;
  assign mem_address = res_data.mem_address;
  assign mem_write_data = res_data.mem_write_data;
  assign illegal_instruction = res_data.illegal_instruction;

  `MIE_ASSERT_IMP(a_no_take_in_clear, busy_clear, !dq_take)
  `MIE_ASSERT_IMP(a_zero_idx_no_we, !empty && reg_write_index == 5'd0, !reg_write_enable)
  `MIE_ASSERT_IMP(a_illegal_quiet, !empty && illegal_instruction,
                  !reg_write_enable && !mem_write_enable)
endmodule

[sim/mips_integer_subset_execute_top_test.sv]
// Testbench for the MIPS integer subset execute block: directed and random instruction streams.
module mips_integer_subset_execute_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mie_pkg::*;

  localparam int unsigned MemWords = DataWordsDefault;
  // Cycles without any beat before the run is declared hung; covers the
  // clearing pass after reset plus the longest idle bursts on both sides.
  localparam int unsigned HangLimit = 8 * MemWords;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [31:0] instruction;
  logic        empty;
  logic        pop;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  res_t        got;

  mips_integer_subset_execute_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .instruction        (instruction),
    .empty              (empty),
    .pop                (pop),
    .next_pc            (got.next_pc),
    .reg_write_enable   (got.reg_write_enable),
    .reg_write_index    (got.reg_write_index),
    .reg_write_value    (got.reg_write_value),
    .mem_write_enable   (got.mem_write_enable),
    .mem_byte_write     (got.mem_byte_write),
    .mem_address        (got.mem_address),
    .mem_write_data     (got.mem_write_data),
    .illegal_instruction(got.illegal_instruction),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Architectural shadow state of the block.
  logic [31:0] start_pc_q;
  logic [31:0] data_base_q;
  logic [31:0] pc_q;
  logic [31:0] gpr [32];
  logic [31:0] dmem [MemWords];

  res_t        pending_q[$];
  int unsigned mismatches;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned idle_cycles;
  bit          allow_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Instruction encoders.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {OpSpecial, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // ---------------------------------------------------------------------------
  // Execute one instruction against the shadow state and return its result.
  // ---------------------------------------------------------------------------
  function automatic logic [9:0] mem_slot(logic [31:0] addr);
    logic [31:0] off;
    off = addr - data_base_q;
    return off[11:2];
  endfunction

  function automatic int unsigned mem_lane(logic [31:0] addr);
    logic [31:0] off;
    off = addr - data_base_q;
    return (3 - off[1:0]) * 8;
  endfunction

  function automatic res_t execute_instr(logic [31:0] w);
    res_t        r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] a, b, simm, zimm, pc4, word;
    logic [7:0]  byte_v;
    logic        wen, bad;
    int unsigned s;
    op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6];
    fn = w[5:0];
    a = gpr[rs]; b = gpr[rt];
    simm = {{16{w[15]}}, w[15:0]};
    zimm = {16'h0, w[15:0]};
    pc4 = pc_q + 32'd4;
    r = '0;
    r.next_pc = pc4;
    wen = 1'b0;
    bad = 1'b0;
    case (op)
      OpSpecial: begin
        wen = 1'b1;
        r.reg_write_index = rd;
        case (fn)
          FnAddu: r.reg_write_value = a + b;
          FnAnd:  r.reg_write_value = a & b;
          FnNor:  r.reg_write_value = ~(a | b);
          FnOr:   r.reg_write_value = a | b;
          FnSltu: r.reg_write_value = {31'h0, a < b};
          FnSll:  r.reg_write_value = b << sh;
          FnSrl:  r.reg_write_value = b >> sh;
          FnSubu: r.reg_write_value = a - b;
          FnJr: begin
            wen = 1'b0;
            r.next_pc = a;
          end
          default: bad = 1'b1;
        endcase
      end
      OpAddiu, OpAndi, OpOri, OpSltiu, OpLui: begin
        wen = 1'b1;
        r.reg_write_index = rt;
        case (op)
          OpAddiu: r.reg_write_value = a + simm;
          OpAndi:  r.reg_write_value = a & zimm;
          OpOri:   r.reg_write_value = a | zimm;
          OpSltiu: r.reg_write_value = {31'h0, a < simm};
          default: r.reg_write_value = {w[15:0], 16'h0};
        endcase
      end
      OpBeq: if (a == b) r.next_pc = pc4 + (simm << 2);
      OpBne: if (a != b) r.next_pc = pc4 + (simm << 2);
      OpLw, OpLb: begin
        r.mem_address = a + simm;
        word = dmem[mem_slot(r.mem_address)];
        wen = 1'b1;
        r.reg_write_index = rt;
        if (op == OpLw) begin
          r.reg_write_value = word;
        end else begin
          byte_v = 8'(word >> mem_lane(r.mem_address));
          r.reg_write_value = {{24{byte_v[7]}}, byte_v};
        end
      end
      OpSw: begin
        r.mem_address = a + simm;
        r.mem_write_enable = 1'b1;
        r.mem_write_data = b;
        dmem[mem_slot(r.mem_address)] = b;
      end
      OpSb: begin
        r.mem_address = a + simm;
        r.mem_write_enable = 1'b1;
        r.mem_byte_write = 1'b1;
        r.mem_write_data = {24'h0, b[7:0]};
        s = mem_lane(r.mem_address);
        word = dmem[mem_slot(r.mem_address)];
        word = (word & ~(32'hFF << s)) | (r.mem_write_data << s);
        dmem[mem_slot(r.mem_address)] = word;
      end
      OpJ, OpJal: begin
        r.next_pc = {pc4[31:28], w[25:0], 2'b00};
        if (op == OpJal) begin
          wen = 1'b1;
          r.reg_write_index = 5'd31;
          r.reg_write_value = pc4;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      r = '0;
      r.next_pc = pc_q;
      r.illegal_instruction = 1'b1;
      wen = 1'b0;
    end
    // Register zero is hardwired: drop the write and report nothing.
    if (!wen || r.reg_write_index == 5'd0) begin
      r.reg_write_enable = 1'b0;
      r.reg_write_index = 5'd0;
      r.reg_write_value = '0;
    end else begin
      r.reg_write_enable = 1'b1;
      gpr[r.reg_write_index] = r.reg_write_value;
    end
    pc_q = r.next_pc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Send one instruction beat; optionally idle first.
  // ---------------------------------------------------------------------------
  task automatic push_instr(input logic [31:0] w);
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    push = 1'b1;
    instruction = w;
    // Hold the beat until the block takes it.
    do @(posedge clk); while (full);
    pending_q.push_back(execute_instr(w));
    beats_in++;
    @(negedge clk);
    push = 1'b0;
    instruction = $urandom;
  endtask

  // Drain everything outstanding, then let the back end settle.
  task automatic drain;
    wait (pending_q.size() == 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [31:0] value);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_data = $urandom;
    // start_pc only matters at the next reset, so the PC is not touched here.
    if (idx == CfgStartPc) start_pc_q = value;
    else data_base_q = value;
  endtask

  // Point r30 at the data window so memory traffic lands near stored words.
  task automatic load_base_reg;
    push_instr(enc_i(OpLui, 5'd0, 5'd30, data_base_q[31:16]));
    push_instr(enc_i(OpOri, 5'd30, 5'd30, data_base_q[15:0]));
  endtask

  // ---------------------------------------------------------------------------
  // Random instruction, mostly legal with random content.
  // ---------------------------------------------------------------------------
  function automatic logic [4:0] pick_reg();
    logic [4:0] r;
    r = 5'($urandom_range(0, 31));
    // Keep r30 as the memory base except for occasional clobbers.
    if (r == 5'd30 && $urandom_range(0, 7) != 0) r = 5'($urandom_range(1, 7));
    return r;
  endfunction

  function automatic logic [31:0] random_instr();
    logic [5:0]  fns [9];
    logic [5:0]  iops [5];
    logic [5:0]  mops [4];
    logic [15:0] off;
    fns  = '{FnSll, FnSrl, FnJr, FnAddu, FnSubu, FnAnd, FnOr, FnNor, FnSltu};
    iops = '{OpAddiu, OpSltiu, OpAndi, OpOri, OpLui};
    mops = '{OpLb, OpLw, OpSb, OpSw};
    off = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 127)) - 64);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4:
        return enc_r(fns[$urandom_range(0, 8)], pick_reg(), pick_reg(), pick_reg(),
                     5'($urandom_range(0, 31)));
      5, 6, 7, 8:
        return enc_i(iops[$urandom_range(0, 4)], pick_reg(), pick_reg(), 16'($urandom));
      9, 10, 11, 12, 13, 14:
        return enc_i(mops[$urandom_range(0, 3)],
                     ($urandom_range(0, 3) == 0) ? pick_reg() : 5'd30, pick_reg(), off);
      15, 16:
        return enc_i($urandom_range(0, 1) ? OpBeq : OpBne, pick_reg(), pick_reg(),
                     16'($urandom));
      17:
        return {$urandom_range(0, 1) ? OpJ : OpJal, 26'($urandom)};
      18:
        // Undefined function code under the special opcode.
        return enc_r(6'h3F, pick_reg(), pick_reg(), pick_reg(), 5'($urandom_range(0, 31)));
      default:
        return $urandom;
    endcase
  endfunction

  task automatic run_random(input int unsigned count);
    load_base_reg();
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 97 == 96) load_base_reg();
      else push_instr(random_instr());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------
  task automatic test_alu_extremes;
    push_instr(enc_i(OpLui, 5'd0, 5'd1, 16'hFFFF));
    push_instr(enc_i(OpOri, 5'd1, 5'd1, 16'hFFFF));
    push_instr(enc_i(OpAddiu, 5'd0, 5'd2, 16'h0001));
    push_instr(enc_r(FnAddu, 5'd1, 5'd2, 5'd3, 5'd7));     // wraps to zero
    push_instr(enc_r(FnSubu, 5'd0, 5'd2, 5'd4, 5'd0));     // wraps to all ones
    push_instr(enc_r(FnAnd, 5'd1, 5'd2, 5'd5, 5'd0));
    push_instr(enc_r(FnOr, 5'd3, 5'd2, 5'd5, 5'd0));
    push_instr(enc_r(FnNor, 5'd0, 5'd0, 5'd6, 5'd0));
    push_instr(enc_r(FnSltu, 5'd2, 5'd1, 5'd7, 5'd0));
    push_instr(enc_i(OpSltiu, 5'd0, 5'd8, 16'h8000));      // sign-extended compare
    push_instr(enc_i(OpAndi, 5'd1, 5'd9, 16'h8000));       // zero-extended mask
    push_instr(enc_r(FnSll, 5'd0, 5'd1, 5'd10, 5'd31));
    push_instr(enc_r(FnSrl, 5'd0, 5'd1, 5'd11, 5'd31));
    push_instr(enc_i(OpAddiu, 5'd1, 5'd0, 16'h0005));      // write to r0 is dropped
    push_instr(enc_r(FnAddu, 5'd0, 5'd0, 5'd12, 5'd0));    // r0 still reads zero
  endtask

  task automatic test_memory;
    load_base_reg();
    push_instr(enc_i(OpSw, 5'd30, 5'd1, 16'h0000));
    push_instr(enc_i(OpSb, 5'd30, 5'd2, 16'h0003));
    push_instr(enc_i(OpLb, 5'd30, 5'd13, 16'h0000));       // sign-extends 0xFF
    push_instr(enc_i(OpLw, 5'd30, 5'd14, 16'h0002));       // unaligned word read
    push_instr(enc_i(OpSw, 5'd30, 5'd2, 16'hFFFC));        // below the window, wraps
    push_instr(enc_i(OpLw, 5'd30, 5'd15, 16'h0FFC));       // same slot from above
  endtask

  task automatic test_control_flow;
    push_instr(enc_i(OpBeq, 5'd0, 5'd0, 16'h8000));        // taken, farthest back
    push_instr(enc_i(OpBne, 5'd0, 5'd0, 16'h7FFF));        // not taken
    push_instr(enc_i(OpBne, 5'd1, 5'd0, 16'h7FFF));        // taken, farthest forward
    push_instr({OpJ, 26'h3FF_FFFF});
    push_instr({OpJal, 26'h000_0000});
    push_instr(enc_r(FnJr, 5'd31, 5'd5, 5'd9, 5'd3));      // unused fields ignored
    push_instr({6'h3F, 26'h3FF_FFFF});                     // unknown opcode
    push_instr(enc_r(6'h01, 5'd1, 5'd1, 5'd1, 5'd0));      // unknown function code
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop bursts, then compare each beat.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    pop = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
        pop = 1'b0;
        hold = $urandom_range(0, 14);
      end else begin
        pop = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      beats_out++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %p", got);
      end else begin
        want = pending_q.pop_front();
        if (want.next_pc !== got.next_pc
            || want.reg_write_enable !== got.reg_write_enable
            || want.reg_write_index !== got.reg_write_index
            || want.reg_write_value !== got.reg_write_value
            || want.mem_write_enable !== got.mem_write_enable
            || want.mem_byte_write !== got.mem_byte_write
            || want.mem_address !== got.mem_address
            || want.mem_write_data !== got.mem_write_data
            || want.illegal_instruction !== got.illegal_instruction) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d mismatch", beats_out);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  // Watchdog: advance a counter on every cycle with no beat on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > HangLimit) begin
      $display("mips_integer_subset_execute_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests.
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    push = 1'b0;
    instruction = '0;
    cfg_we = 1'b0;
    cfg_index = CfgStartPc;
    cfg_data = '0;
    allow_idle = 1'b1;
    mismatches = 0;
    beats_in = 0;
    beats_out = 0;
    idle_cycles = 0;
    start_pc_q = StartPcReset;
    data_base_q = DataBaseReset;
    pc_q = StartPcReset;
    foreach (gpr[k]) gpr[k] = '0;
    foreach (dmem[k]) dmem[k] = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_alu_extremes();
    test_memory();
    test_control_flow();
    run_random(450);

    write_cfg(CfgStartPc, 32'h0000_0000);
    write_cfg(CfgDataBase, 32'h0000_0000);
    test_memory();
    run_random(300);

    write_cfg(CfgStartPc, 32'hFFFF_FFFC);
    write_cfg(CfgDataBase, 32'hFFFF_FFFC);
    test_memory();
    run_random(300);

    write_cfg(CfgDataBase, {$urandom} & 32'hFFFF_FFFC);
    allow_idle = 1'b0;
    run_random(350);

    fork
      wait (pending_q.size() == 0);
      repeat (HangLimit) @(negedge clk);
    join_any
    disable fork;
    repeat (10) @(negedge clk);

    $display("Covered %0d instructions over four data window settings and %0d results.",
             beats_in, beats_out);
    $display("Random push and pop stalls ran in all but the last phase; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("mips_integer_subset_execute_top test passed");
    end else begin
      $display("mips_integer_subset_execute_top test failed");
    end
    $finish;
  end
endmodule

[mips_integer_subset_execute_top.f]
+incdir+hw/rtl
hw/rtl/mie_pkg.sv
hw/rtl/mie_ram.sv
hw/rtl/mie_front.sv
hw/rtl/mie_back.sv
hw/rtl/mips_integer_subset_execute_top.sv
sim/mips_integer_subset_execute_top_test.sv
